// ===== rtl/dmtt_pkg.sv =====
// Shared types, constants and the score function for the transposition table core.
package dmtt_pkg;

    localparam int INDEX_BITS = 12;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;
    localparam int KEY_BITS   = 64;
    localparam int FILL_BITS  = 21;
    localparam logic [FILL_BITS-1:0] FILL_MAX = {FILL_BITS{1'b1}};

    localparam int MATE_LIMIT  = 32000;
    localparam int MATE_MARGIN = 128;
    localparam logic signed [17:0] MATE_EDGE = 18'(MATE_LIMIT - MATE_MARGIN);
    localparam logic signed [17:0] SCORE_CAP = 18'(32767);

    localparam logic FUNC_PROBE = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    localparam logic [1:0] BND_NONE  = 2'd0;
    localparam logic [1:0] BND_EXACT = 2'd1;
    localparam logic [1:0] BND_LOWER = 2'd2;
    localparam logic [1:0] BND_UPPER = 2'd3;

    typedef struct packed {
        logic                func;
        logic [KEY_BITS-1:0] key;
        logic [15:0]         move;
        logic signed [15:0]  score;
        logic [6:0]          depth;
        logic [1:0]          bound;
        logic [6:0]          ply;
        logic signed [15:0]  alpha;
        logic signed [15:0]  beta;
        logic                pv_node;
    } in_t;

    typedef struct packed {
        logic                 hit;
        logic [15:0]          hit_move;
        logic                 cutoff;
        logic signed [15:0]   cutoff_score;
        logic [FILL_BITS-1:0] filled_count;
    } out_t;

    typedef struct packed {
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [6:0]         depth;
        logic [1:0]         bound;
    } entry_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] tag;
        entry_t              entry;
    } slot_t;

    // Mate scores move away from zero by ply when stored and back toward zero
    // when read; the result saturates to the symmetric 16-bit score range.
    function automatic logic signed [15:0] mate_adjust(
        input logic signed [15:0] s,
        input logic [6:0]         ply,
        input logic               to_store
    );
        logic signed [17:0] sx;
        logic signed [17:0] delta;
        logic signed [17:0] r;
        sx    = {{2{s[15]}}, s};
        delta = to_store ? {11'd0, ply} : -{11'd0, ply};
        if (sx >= MATE_EDGE) begin
            r = sx + delta;
        end else if (sx <= -MATE_EDGE) begin
            r = sx - delta;
        end else begin
            r = sx;
        end
        if (r > SCORE_CAP) begin
            r = SCORE_CAP;
        end else if (r < -SCORE_CAP) begin
            r = -SCORE_CAP;
        end
        return r[15:0];
    endfunction

endpackage

// ===== rtl/dmtt_eval.sv =====
// Combinational evaluation of one probe or store against the slot read from the table.
module dmtt_eval (
    input  dmtt_pkg::in_t                      req,
    input  dmtt_pkg::slot_t                    slot,
    input  logic [dmtt_pkg::FILL_BITS-1:0]     count,
    output dmtt_pkg::out_t                     resp,
    output dmtt_pkg::slot_t                    wr_slot,
    output logic [dmtt_pkg::FILL_BITS-1:0]     count_next
);
    import dmtt_pkg::*;

    logic               tag_match;
    logic               is_store;
    logic signed [15:0] read_score;
    logic               depth_ok;
    logic               bound_ok;

    assign is_store   = (req.func == FUNC_STORE);
    assign tag_match  = (slot.tag == req.key);
    assign read_score = mate_adjust(slot.entry.score, req.ply, 1'b0);
    assign depth_ok   = (slot.entry.depth >= req.depth);

    always_comb begin
        case (slot.entry.bound)
            BND_EXACT: bound_ok = 1'b1;
            BND_LOWER: bound_ok = (read_score >= req.beta);
            BND_UPPER: bound_ok = (read_score <= req.alpha);
            default:   bound_ok = 1'b0;
        endcase
    end

    always_comb begin
        wr_slot.tag         = req.key;
        wr_slot.entry.move  = req.move;
        wr_slot.entry.score = mate_adjust(req.score, req.ply, 1'b1);
        wr_slot.entry.depth = req.depth;
        wr_slot.entry.bound = req.bound;

        count_next = count;
        if (is_store && (slot.tag == '0) && (count != FILL_MAX)) begin
            count_next = count + 1'b1;
        end

        resp              = '0;
        resp.filled_count = count_next;
        if (!is_store && tag_match) begin
            resp.hit      = 1'b1;
            resp.hit_move = slot.entry.move;
            if (!req.pv_node && depth_ok && bound_ok) begin
                resp.cutoff       = 1'b1;
                resp.cutoff_score = read_score;
            end
        end
    end

endmodule

// ===== rtl/direct_mapped_transposition_table_core.sv =====
// Top level of the direct-mapped, always-replace transposition table core.
// m_valid rises in the cycle after the input transfer (the table is read at the transfer
// edge; evaluation and write-back into the output register follow in ST_LOOK).
// No new probe or store is taken until the current one has finished the read-modify-write
// of the slot memory. After aresetn the core sweeps all SLOT_COUNT (4096) slots
// to zero, one per cycle, and holds s_ready low until the sweep is done.
module direct_mapped_transposition_table_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dmtt_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output dmtt_pkg::out_t  m_data
);
    import dmtt_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_idx_reg, clr_idx_next;
    logic [FILL_BITS-1:0]  count_reg, count_next;
    in_t                   req_reg;
    slot_t                 rd_slot_reg;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg;

    slot_t                 mem [SLOT_COUNT];

    logic                  s_xfer;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    slot_t                 wr_data;
    out_t                  resp;
    slot_t                 eval_slot;
    logic [FILL_BITS-1:0]  eval_count;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    dmtt_eval u_eval (
        .req        (req_reg),
        .slot       (rd_slot_reg),
        .count      (count_reg),
        .resp       (resp),
        .wr_slot    (eval_slot),
        .count_next (eval_count)
    );

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        wr_en        = 1'b0;
        wr_addr      = req_reg.key[INDEX_BITS-1:0];
        wr_data      = eval_slot;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                wr_data      = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (&clr_idx_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                // The output register is known to be free here: the transfer
                // was only taken when it was empty or being drained.
                wr_en        = (req_reg.func == FUNC_STORE);
                count_next   = eval_count;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_LOOK) begin
            m_data_reg <= resp;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_slot_reg <= mem[s_data.key[INDEX_BITS-1:0]];
    end

endmodule

// ===== sim/direct_mapped_transposition_table_core_test.sv =====
// Self-checking testbench for the direct-mapped transposition table core.
module direct_mapped_transposition_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dmtt_pkg::*;

    localparam int SCORE_LIMIT = 32767;
    localparam int MATE_BAND   = MATE_LIMIT - MATE_MARGIN;
    // The core clears every slot after reset before it takes the first transfer.
    localparam int STALL_LIMIT = 20000;
    localparam int POOL_DEPTH  = 48;

    typedef struct {
        bit   typed;
        out_t want;
    } typed_note_t;

    typedef struct {
        in_t         req;
        typed_note_t note;
    } script_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    int send_idle_pct = 6;
    int recv_idle_pct = 88;

    // Shadow copy of the slot memory and fill counter.
    logic [KEY_BITS-1:0]  table_tags    [SLOT_COUNT];
    entry_t               table_entries [SLOT_COUNT];
    logic [FILL_BITS-1:0] slots_filled;

    out_t          pending_outcomes [$];
    typed_note_t   typed_notes      [$];
    logic [63:0]   key_pool         [$];
    script_row_t   script           [$];

    int mismatch_count = 0;
    int result_count   = 0;
    int stall_cycles   = 0;

    direct_mapped_transposition_table_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic signed [15:0] shift_mate(input int s, input int ply,
                                                      input bit storing);
        int r;
        r = s;
        if (s >= MATE_BAND) begin
            r = storing ? s + ply : s - ply;
        end else if (s <= -MATE_BAND) begin
            r = storing ? s - ply : s + ply;
        end
        if (r > SCORE_LIMIT) begin
            r = SCORE_LIMIT;
        end else if (r < -SCORE_LIMIT) begin
            r = -SCORE_LIMIT;
        end
        return 16'(r);
    endfunction

    function automatic out_t predict_table_access(input in_t req);
        logic [INDEX_BITS-1:0] slot;
        entry_t held;
        out_t   res;
        int     s;
        bit     allowed;
        slot = req.key[INDEX_BITS-1:0];
        res  = '0;
        if (req.func == FUNC_STORE) begin
            if (table_tags[slot] == '0 && slots_filled != FILL_MAX) begin
                slots_filled = slots_filled + 1'b1;
            end
            table_tags[slot]    = req.key;
            table_entries[slot] = '{move:  req.move,
                                    score: shift_mate($signed(req.score), int'(req.ply), 1'b1),
                                    depth: req.depth,
                                    bound: req.bound};
        end else if (table_tags[slot] == req.key) begin
            held         = table_entries[slot];
            res.hit      = 1'b1;
            res.hit_move = held.move;
            if (!req.pv_node && held.depth >= req.depth) begin
                s = shift_mate($signed(held.score), int'(req.ply), 1'b0);
                case (held.bound)
                    BND_EXACT: allowed = 1'b1;
                    BND_LOWER: allowed = (s >= int'($signed(req.beta)));
                    BND_UPPER: allowed = (s <= int'($signed(req.alpha)));
                    default:   allowed = 1'b0;
                endcase
                if (allowed) begin
                    res.cutoff       = 1'b1;
                    res.cutoff_score = 16'(s);
                end
            end
        end
        res.filled_count = slots_filled;
        return res;
    endfunction

    function automatic in_t mk_req(input logic func, input logic [63:0] key,
                                   input int move, input int score,
                                   input int depth, input logic [1:0] bound, input int ply,
                                   input int alpha, input int beta, input int pv_node);
        in_t r;
        r.func    = func;
        r.key     = key;
        r.move    = 16'(move);
        r.score   = 16'(score);
        r.depth   = 7'(depth);
        r.bound   = bound;
        r.ply     = 7'(ply);
        r.alpha   = 16'(alpha);
        r.beta    = 16'(beta);
        r.pv_node = 1'(pv_node);
        return r;
    endfunction

    function automatic out_t mk_out(input int hit, input int move,
                                    input int cutoff, input int score, input int filled);
        out_t r;
        r.hit          = 1'(hit);
        r.hit_move     = 16'(move);
        r.cutoff       = 1'(cutoff);
        r.cutoff_score = 16'(score);
        r.filled_count = FILL_BITS'(filled);
        return r;
    endfunction

    function automatic void add_row(input in_t req, input typed_note_t note);
        script.insert(script.size(), '{req, note});
    endfunction

    // Scores lean toward the mate band so that the ply adjustment and saturation get hit.
    function automatic logic signed [15:0] random_score();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            return 16'($urandom);
        end else if (pick < 30) begin
            return 16'($urandom_range(31800, 32767));
        end else if (pick < 45) begin
            return 16'(-int'($urandom_range(31800, 32768)));
        end
        return 16'(int'($urandom_range(0, 6000)) - 3000);
    endfunction

    // Keys mostly revisit recent stores so that probes hit and stores replace.
    function automatic logic [63:0] random_key();
        int          pick;
        logic [63:0] k;
        pick = $urandom_range(99);
        k    = {$urandom, $urandom};
        if (pick < 55 && key_pool.size() > 0) begin
            return key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (pick < 62) begin
            return '0;
        end else if (pick < 80) begin
            k[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(15));
        end
        return k;
    endfunction

    function automatic in_t random_request();
        in_t r;
        r.func    = ($urandom_range(99) < 45) ? FUNC_STORE : FUNC_PROBE;
        r.key     = random_key();
        r.move    = 16'($urandom);
        r.score   = random_score();
        r.bound   = 2'($urandom_range(3));
        r.ply     = 7'($urandom_range(127));
        r.pv_node = ($urandom_range(99) < 25);
        if (r.func == FUNC_STORE || $urandom_range(99) < 30) begin
            r.depth = 7'($urandom_range(127));
        end else begin
            r.depth = 7'($urandom_range(20));
        end
        r.alpha = ($urandom_range(99) < 20) ? 16'($urandom) : random_score();
        r.beta  = ($urandom_range(99) < 20) ? 16'($urandom) : random_score();
        if (r.func == FUNC_STORE) begin
            key_pool.insert(key_pool.size(), r.key);
            if (key_pool.size() > POOL_DEPTH) begin
                void'(key_pool.pop_front());
            end
        end
        return r;
    endfunction

    // Holds valid and payload until the transfer happens; returns at that edge.
    task automatic send_request(input in_t req, input typed_note_t note);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        typed_notes.insert(typed_notes.size(), note);
        s_valid <= 1'b1;
        s_data  <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_outcomes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        out_t        want;
        typed_note_t note;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                result_count++;
                if (pending_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result %0d arrived with nothing outstanding", result_count);
                    end
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_data.hit !== want.hit || m_data.hit_move !== want.hit_move
                        || m_data.cutoff !== want.cutoff
                        || m_data.cutoff_score !== want.cutoff_score
                        || m_data.filled_count !== want.filled_count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("result %0d expected hit=%0d move=%h cut=%0d score=%0d fill=%0d",
                                     result_count, want.hit, want.hit_move, want.cutoff,
                                     $signed(want.cutoff_score), want.filled_count);
                            $display("result %0d actual   hit=%0d move=%h cut=%0d score=%0d fill=%0d",
                                     result_count, m_data.hit, m_data.hit_move, m_data.cutoff,
                                     $signed(m_data.cutoff_score), m_data.filled_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = predict_table_access(s_data);
                note = typed_notes.pop_front();
                if (note.typed) begin
                    want = note.want;
                end
                pending_outcomes.insert(pending_outcomes.size(), want);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        typed_note_t no_note;
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        logic [63:0] key_d;
        no_note = '{typed: 1'b0, want: '0};
        key_a   = 64'hFFFF_FFFF_FFFF_FFFF;
        key_b   = 64'h8000_0000_0000_0123;
        key_c   = 64'h0123_4567_89AB_C123;  // same slot as key_b
        key_d   = 64'h0000_0000_0000_1000;  // same slot as key zero
        for (int i = 0; i < SLOT_COUNT; i++) begin
            table_tags[i]    = '0;
            table_entries[i] = '0;
        end
        slots_filled = '0;

        // Typed rows are read straight off the rules; the rest go through the predictor.
        add_row(mk_req(FUNC_PROBE, '0, 0, 0, 0, BND_NONE, 0, 0, 0, 0),
                '{1'b1, mk_out(1, 0, 0, 0, 0)});
        add_row(mk_req(FUNC_PROBE, key_a, 0, 0, 0, BND_NONE, 0, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 0)});
        add_row(mk_req(FUNC_STORE, key_a, 16'hFFFF, 32767, 127, BND_EXACT, 127, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 1)});
        add_row(mk_req(FUNC_PROBE, key_a, 0, 0, 127, BND_NONE, 127, 0, 0, 0), no_note);
        add_row(mk_req(FUNC_PROBE, key_a, 0, 0, 0, BND_NONE, 0, 0, 0, 1),
                '{1'b1, mk_out(1, 16'hFFFF, 0, 0, 1)});
        add_row(mk_req(FUNC_STORE, key_b, 16'h1234, -32768, 10, BND_LOWER, 127, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 2)});
        add_row(mk_req(FUNC_PROBE, key_b, 0, 0, 10, BND_NONE, 0, 0, -32768, 0), no_note);
        add_row(mk_req(FUNC_PROBE, key_b, 0, 0, 11, BND_NONE, 0, 0, -32768, 0), no_note);
        add_row(mk_req(FUNC_PROBE, key_b, 0, 0, 0, BND_NONE, 0, 0, 0, 0), no_note);
        add_row(mk_req(FUNC_STORE, key_c, 16'h5A5A, 100, 5, BND_UPPER, 3, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 2)});
        add_row(mk_req(FUNC_PROBE, key_b, 0, 0, 0, BND_NONE, 0, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 2)});
        add_row(mk_req(FUNC_PROBE, key_c, 0, 0, 5, BND_NONE, 3, 100, 32767, 0), no_note);
        add_row(mk_req(FUNC_PROBE, key_c, 0, 0, 5, BND_NONE, 3, 99, 32767, 0), no_note);
        // Storing key zero leaves the tag zero, so every such store counts as a new fill.
        add_row(mk_req(FUNC_STORE, '0, 16'h7777, -31872, 0, BND_EXACT, 1, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 3)});
        add_row(mk_req(FUNC_STORE, '0, 16'h7777, -31872, 0, BND_EXACT, 1, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 4)});
        add_row(mk_req(FUNC_PROBE, '0, 0, 0, 0, BND_NONE, 1, 0, 0, 0), no_note);
        add_row(mk_req(FUNC_STORE, key_d, 16'h8001, 31871, 127, BND_NONE, 5, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 5)});
        add_row(mk_req(FUNC_PROBE, key_d, 0, 0, 0, BND_NONE, 0, 32767, -32768, 0), no_note);
        add_row(mk_req(FUNC_PROBE, '0, 0, 0, 0, BND_NONE, 0, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 5)});
        add_row(mk_req(FUNC_STORE, key_a, 0, 31872, 0, BND_EXACT, 0, 0, 0, 0),
                '{1'b1, mk_out(0, 0, 0, 0, 5)});
        add_row(mk_req(FUNC_PROBE, key_a, 0, 0, 0, BND_NONE, 127, 32767, -32768, 0),
                no_note);
        add_row(mk_req(FUNC_PROBE, key_a, 0, 0, 1, BND_NONE, 127, 32767, -32768, 0),
                no_note);
        add_row(mk_req(FUNC_PROBE, 64'h7FFF_0000_FFFF_0FFF, 0, -32768, 127, BND_UPPER,
                       127, -32768, 32767, 1),
                '{1'b1, mk_out(0, 0, 0, 0, 5)});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            send_request(script[i].req, script[i].note);
        end
        // Hold the sender off until every outstanding result is back.
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 6;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 443; n++) begin
                send_request(random_request(), no_note);
            end
            drain_results();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
